>>> rtl/pre_pkg.sv
// ----------------------------------------------------------------------------
// pre_pkg
// Shared types, constants and helpers of the printable run extractor.
// ----------------------------------------------------------------------------
package pre_pkg;

	localparam int PREFIX_DEPTH = 32;
	localparam int ADDR_W       = (PREFIX_DEPTH > 1) ? $clog2(PREFIX_DEPTH) : 1;
	localparam int CNT_W        = $clog2(PREFIX_DEPTH + 1);
	localparam int MIN_W        = 6;
	localparam int PADDR_W      = 3;
	localparam int PDATA_W      = 32;

	localparam logic [7:0] CHAR_TAB     = 8'h09;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_TILDE   = 8'h7E;

	localparam logic [MIN_W-1:0] MIN_LENGTH_RESET = MIN_W'(4);
	localparam logic             REG_MIN_LENGTH   = 1'b0;

	typedef enum logic {
		ST_IDLE,
		ST_BURST
	} pre_state_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} pre_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} pre_rd_t;

	function automatic logic byte_is_text(input logic [7:0] c);
		return (c == CHAR_TAB) || ((c >= CHAR_SPACE) && (c <= CHAR_TILDE));
	endfunction

	function automatic logic [CNT_W-1:0] eff_min(input logic [MIN_W-1:0] m);
		logic [CNT_W-1:0] r;
		if (m == '0) begin
			r = CNT_W'(1);
		end else if (int'(m) > PREFIX_DEPTH) begin
			r = CNT_W'(PREFIX_DEPTH);
		end else begin
			r = CNT_W'(m);
		end
		return r;
	endfunction

endpackage

>>> rtl/pre_in_if.sv
// ----------------------------------------------------------------------------
// pre_in_if
// Input byte stream channel with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pre_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_file;

	modport source (output valid, data_byte, end_of_file, input ready);
	modport sink   (input valid, data_byte, end_of_file, output ready);
endinterface

>>> rtl/pre_out_if.sv
// ----------------------------------------------------------------------------
// pre_out_if
// Output byte stream channel with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pre_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_burst;

	modport source (output valid, out_byte, last_of_burst, input ready);
	modport sink   (input valid, out_byte, last_of_burst, output ready);
endinterface

>>> rtl/pre_store.sv
// ----------------------------------------------------------------------------
// pre_store
// Prefix store: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module pre_store
	import pre_pkg::*;
(
	input  logic       clk,
	input  pre_wr_t    wr,
	input  pre_rd_t    rd,
	output logic [7:0] rd_data
);

	logic [7:0] mem [PREFIX_DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_q <= mem[rd.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/printable_run_extractor.sv
// ----------------------------------------------------------------------------
// printable_run_extractor
// Passes on printable byte runs of at least the clamped min_length bytes, each run
// closed by a newline. The run prefix is held in a memory until released.
//
//   channel     dir   handshake        payload
//   in_stream   in    valid/ready      data_byte[7:0], end_of_file
//   out_stream  out   valid/ready      out_byte[7:0], last_of_burst
//   apb         in    psel/penable     paddr[2:0], pwdata/prdata[31:0]
//
// A transaction that releases the prefix keeps the input stalled while
// the clamped min_length (1 to 32) bytes of the prefix memory are read
// out one byte a cycle.
// The output register stalls that read-out when out_stream is not ready.
// Reset clears the run state and sets min_length to 4; the memory is not
// cleared.
// ----------------------------------------------------------------------------
module printable_run_extractor
	import pre_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	pre_in_if.sink             in_stream,
	pre_out_if.source          out_stream,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	pre_state_t       state_q;
	pre_state_t       state_d;
	logic [MIN_W-1:0] min_length_q;
	logic [CNT_W-1:0] run_q;
	logic             pass_q;
	logic [CNT_W-1:0] len_q;
	logic [CNT_W-1:0] rd_q;
	logic             pend_s1;
	logic             last_s1;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;

	logic [CNT_W-1:0] m;
	logic [CNT_W-1:0] run_inc;
	logic             printable;
	logic             out_free;
	logic             accept;
	logic             single_load;
	logic             burst_start;
	logic             burst_load;
	logic             rd_issue;
	logic             burst_done;
	logic [7:0]       rd_data;
	pre_wr_t          wr;
	pre_rd_t          rd;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MIN_LENGTH) ? PDATA_W'(min_length_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= MIN_LENGTH_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_MIN_LENGTH) begin
			min_length_q <= pwdata[MIN_W-1:0];
		end
	end

	assign m         = eff_min(min_length_q);
	assign run_inc   = run_q + CNT_W'(1);
	assign printable = !in_stream.end_of_file && byte_is_text(in_stream.data_byte);
	assign out_free  = !out_valid_q || out_stream.ready;
	assign burst_done = (rd_q == len_q) && (!pend_s1 || out_free);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (burst_start) begin
					state_d = ST_BURST;
				end
			end
			ST_BURST: begin
				if (burst_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stream.ready = 1'b0;
		burst_load      = 1'b0;
		rd_issue        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stream.ready = out_free;
			end
			ST_BURST: begin
				burst_load = pend_s1 && out_free;
				rd_issue   = (rd_q != len_q) && (!pend_s1 || out_free);
			end
			default: begin
				in_stream.ready = 1'b0;
			end
		endcase
	end

	assign accept      = in_stream.valid && in_stream.ready;
	assign single_load = accept && pass_q;
	assign burst_start = accept && printable && !pass_q && (run_inc >= m);

	always_comb begin
		wr.en   = accept && printable && !pass_q && (int'(run_q) < PREFIX_DEPTH);
		wr.addr = run_q[ADDR_W-1:0];
		wr.data = in_stream.data_byte;
		rd.en   = rd_issue;
		rd.addr = rd_q[ADDR_W-1:0];
	end

	pre_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			run_q   <= '0;
			pass_q  <= 1'b0;
			len_q   <= '0;
			rd_q    <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (printable) begin
					if (pass_q) begin
						run_q <= (run_q > m) ? m : run_q;
					end else begin
						run_q <= (run_inc > m) ? m : run_inc;
						if (run_inc >= m) begin
							pass_q <= 1'b1;
							len_q  <= m;
							rd_q   <= '0;
						end
					end
				end else begin
					run_q  <= '0;
					pass_q <= 1'b0;
				end
			end
			if (rd_issue) begin
				rd_q    <= rd_q + CNT_W'(1);
				pend_s1 <= 1'b1;
			end else if (burst_load) begin
				pend_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			last_s1 <= (rd_q + CNT_W'(1)) == len_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (single_load || burst_load) begin
			out_valid_q <= 1'b1;
		end else if (out_stream.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (single_load) begin
			out_byte_q <= printable ? in_stream.data_byte : CHAR_NEWLINE;
			out_last_q <= 1'b1;
		end else if (burst_load) begin
			out_byte_q <= rd_data;
			out_last_q <= last_s1;
		end
	end

	assign out_stream.valid         = out_valid_q;
	assign out_stream.out_byte      = out_byte_q;
	assign out_stream.last_of_burst = out_last_q;

endmodule
